### src/fpec_pkg.sv
package fpec_pkg;

  localparam int FLASH_BYTES  = 65536;
  localparam int SECTOR_BYTES = 8192;
  localparam int PAGE_BYTES   = 128;
  localparam int PHRASE_BYTES = 16;

  localparam int FLASH_WORDS  = FLASH_BYTES / 4;
  localparam int SECTOR_WORDS = SECTOR_BYTES / 4;
  localparam int PAGE_WORDS   = PAGE_BYTES / 4;
  localparam int PHRASE_WORDS = PHRASE_BYTES / 4;
  localparam int HALF_WORDS   = FLASH_WORDS / 2;
  localparam int FW_AW        = $clog2(FLASH_WORDS);
  localparam int SB_AW        = $clog2(PAGE_WORDS);

  localparam logic [31:0] ONES = 32'hFFFF_FFFF;

  // Bus operation codes.
  localparam logic [1:0] OP_REG_RD = 2'd0;
  localparam logic [1:0] OP_REG_WR = 2'd1;
  localparam logic [1:0] OP_FL_ST  = 2'd2;
  localparam logic [1:0] OP_FL_RD  = 2'd3;

  // Register offsets.
  localparam logic [15:0] REG_STATUS  = 16'h0000;
  localparam logic [15:0] REG_CONFIG  = 16'h0004;
  localparam logic [15:0] REG_CONTROL = 16'h0008;
  localparam logic [15:0] REG_CMD_LO  = 16'h0010;
  localparam logic [15:0] REG_CMD_HI  = 16'h0030;

  // Status bits.
  localparam int ST_FAIL   = 0;
  localparam int ST_ABT    = 2;
  localparam int ST_PVIOL  = 4;
  localparam int ST_ACCERR = 5;
  localparam int ST_IDLE   = 7;
  localparam int ST_WIN_LO = 24;
  localparam int ST_WIN_HI = 25;
  localparam int ST_READY  = 31;
  localparam logic [31:0] ST_ERRORS = 32'h0000_0035;
  localparam int CFG_IE    = 7;
  localparam int CTL_ABORT = 24;

  localparam logic [1:0] WIN_PHRASE = 2'd1;
  localparam logic [1:0] WIN_PAGE   = 2'd2;

  // Command codes.
  localparam logic [7:0] CMD_CHK_ALL   = 8'h00;
  localparam logic [7:0] CMD_CHK_BLK   = 8'h01;
  localparam logic [7:0] CMD_CHK_SEC   = 8'h02;
  localparam logic [7:0] CMD_CHK_PAGE  = 8'h03;
  localparam logic [7:0] CMD_CHK_PHR   = 8'h04;
  localparam logic [7:0] CMD_PRG_PAGE  = 8'h23;
  localparam logic [7:0] CMD_PRG_PHR   = 8'h24;
  localparam logic [7:0] CMD_ERS_ALL   = 8'h40;
  localparam logic [7:0] CMD_ERS_SEC   = 8'h42;

  typedef enum logic [1:0] {
    MODE_ERASE = 2'd0,
    MODE_CHECK = 2'd1,
    MODE_PROG  = 2'd2
  } sweep_mode_t;

  typedef struct packed {
    sweep_mode_t      mode;
    logic [FW_AW-1:0] first;
    logic [FW_AW-1:0] last;
  } sweep_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             fail;
  } sweep_stat_t;

  typedef struct packed {
    logic             fl_we;
    logic [FW_AW-1:0] fl_waddr;
    logic [31:0]      fl_wdata;
    logic             fl_re;
    logic [FW_AW-1:0] fl_raddr;
    logic [SB_AW-1:0] sb_raddr;
  } mem_req_t;

endpackage

### src/fpec_ram.sv
module fpec_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/fpec_sweep.sv
module fpec_sweep (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start_i,
  input  fpec_pkg::sweep_cmd_t  cmd_i,
  input  logic [31:0]           fl_rdata_i,
  input  logic [31:0]           sb_rdata_i,
  output fpec_pkg::mem_req_t    req_o,
  output fpec_pkg::sweep_stat_t stat_o
);

  typedef enum logic [3:0] {
    SW_IDLE  = 4'b0001,
    SW_ERASE = 4'b0010,
    SW_RD    = 4'b0100,
    SW_EVAL  = 4'b1000
  } sw_state_t;

  sw_state_t                      state_r, state_nxt;
  fpec_pkg::sweep_mode_t          mode_r, mode_nxt;
  logic [fpec_pkg::FW_AW-1:0]     ptr_r, ptr_nxt;
  logic [fpec_pkg::FW_AW-1:0]     idx_r, idx_nxt;
  logic [fpec_pkg::FW_AW-1:0]     last_r, last_nxt;
  logic                           fail_r, fail_nxt;
  logic [31:0]                    merged;
  logic                           word_fail;

  // After reset the sequencer clears the whole array before anything else.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SW_ERASE;
      mode_r  <= fpec_pkg::MODE_ERASE;
      ptr_r   <= '0;
      idx_r   <= '0;
      last_r  <= fpec_pkg::FW_AW'(fpec_pkg::FLASH_WORDS - 1);
      fail_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      ptr_r   <= ptr_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
      fail_r  <= fail_nxt;
    end
  end

  assign merged = fl_rdata_i & sb_rdata_i;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    ptr_nxt   = ptr_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    fail_nxt  = fail_r;
    word_fail = 1'b0;
    req_o     = '0;
    stat_o    = '0;
    stat_o.busy = (state_r != SW_IDLE);
    req_o.fl_raddr = ptr_r;
    req_o.fl_waddr = ptr_r;
    req_o.sb_raddr = idx_r[fpec_pkg::SB_AW-1:0];
    case (state_r)
      SW_IDLE: begin
        if (start_i) begin
          mode_nxt  = cmd_i.mode;
          ptr_nxt   = cmd_i.first;
          idx_nxt   = '0;
          last_nxt  = cmd_i.last;
          fail_nxt  = 1'b0;
          state_nxt = (cmd_i.mode == fpec_pkg::MODE_ERASE) ? SW_ERASE : SW_RD;
        end
      end
      SW_ERASE: begin
        req_o.fl_we    = 1'b1;
        req_o.fl_wdata = fpec_pkg::ONES;
        if (idx_r == last_r) begin
          stat_o.done = 1'b1;
          state_nxt   = SW_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      SW_RD: begin
        req_o.fl_re = 1'b1;
        state_nxt   = SW_EVAL;
      end
      SW_EVAL: begin
        state_nxt = SW_RD;
        if (mode_r == fpec_pkg::MODE_PROG) begin
          req_o.fl_we    = 1'b1;
          req_o.fl_wdata = merged;
          word_fail      = (merged != sb_rdata_i);
        end else begin
          word_fail      = (fl_rdata_i != fpec_pkg::ONES);
        end
        // A failing word anywhere in the walk is kept until the walk ends.
        stat_o.fail = fail_r | word_fail;
        fail_nxt    = fail_r | word_fail;
        // A read-ones check stops at the first word that is not erased.
        if (idx_r == last_r ||
            (mode_r == fpec_pkg::MODE_CHECK && fl_rdata_i != fpec_pkg::ONES)) begin
          stat_o.done = 1'b1;
          state_nxt   = SW_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = SW_IDLE;
      end
    endcase
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != SW_IDLE) |-> (idx_r <= last_r))
    else $error("sweep index ran past its last word");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat_o.done |=> (state_r == SW_IDLE))
    else $error("sweep still running after done");
  a_rd_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SW_RD) |=> (state_r == SW_EVAL))
    else $error("read phase not followed by evaluation");

endmodule

### src/flash_program_erase_controller.sv
// Register reads and writes, flash stores and commands that need no array
// walk give their result transfer in the cycle after the input transfer.
// A flash read goes through the registered array read in state T_FREAD first.
// Erase-all and sector erase walk one word a cycle; read-ones checks and
// page or phrase commits take each word through a read and then an evaluate step.
// Reset is synchronous and active low; afterwards an erase pass over all
// 16384 words writes the array to all ones while no input transfer is taken.
module flash_program_erase_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, lowest bit up: address[15:0], write_data[47:16],
  // access_bytes[50:48], zero fill[55:51].
  input  logic [55:0] in_tdata,
  // in_tuser: opcode[1:0].
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, lowest bit up: read_data[31:0], irq_level[32], zero fill[39:33].
  output logic [39:0] out_tdata
);

  // Top level sequencing: the one-hot states below cover the initial clear,
  // waiting for a transfer, the flash read delay and a running array walk.
  typedef enum logic [3:0] {
    T_INIT  = 4'b0001,
    T_IDLE  = 4'b0010,
    T_FREAD = 4'b0100,
    T_SWEEP = 4'b1000
  } top_state_t;

  top_state_t   state_r, state_nxt;
  logic [31:0]  status_r, status_nxt;
  logic [31:0]  config_r, config_nxt;
  logic [31:0]  control_r, control_nxt;
  logic [31:0]  cmdw_r [8];
  logic [31:0]  cmdw_nxt [8];
  logic [15:0]  base_r, base_nxt;
  logic [5:0]   taken_r, taken_nxt;
  logic [5:0]   needed_r, needed_nxt;
  logic [7:0]   staged_r, staged_nxt;
  logic         open_r, open_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  out_rd_r, out_rd_nxt;
  logic         out_irq_r, out_irq_nxt;

  logic [1:0]   op;
  logic [15:0]  addr;
  logic [31:0]  wdata;
  logic [2:0]   nbytes;
  logic         accept;
  logic         produce;
  logic         blocked;
  logic [7:0]   cmd;
  logic [15:0]  caddr;
  logic [2:0]   cidx;
  logic [15:0]  align_mask;

  logic                   sw_start;
  fpec_pkg::sweep_cmd_t   sw_cmd;
  fpec_pkg::sweep_stat_t  sw_stat;
  fpec_pkg::mem_req_t     sw_req;
  logic [31:0]            fl_rdata;
  logic [31:0]            sb_rdata;
  logic                   cpu_re;
  logic                   sb_we;

  assign op     = in_tuser;
  assign addr   = in_tdata[15:0];
  assign wdata  = in_tdata[47:16];
  assign nbytes = in_tdata[50:48];
  // Only one item is in the block at a time; the output register may be
  // emptied in the same cycle as the next input transfer is taken.
  assign in_tready = (state_r == T_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign cmd       = cmdw_r[0][7:0];
  assign caddr     = cmdw_r[2][15:0];
  // Command words sit at 0x10..0x2F; the index is the offset less 0x10, in words.
  assign cidx      = {~addr[4], addr[3:2]};
  assign align_mask = {8'd0, needed_r, 2'd0} - 16'd1;
  assign cpu_re    = accept && (op == fpec_pkg::OP_FL_RD);
  assign sb_we     = accept && (op == fpec_pkg::OP_FL_ST) && open_r &&
                     (status_r[fpec_pkg::ST_WIN_HI:fpec_pkg::ST_WIN_LO] != 2'd0) &&
                     (nbytes == 3'd4) &&
                     ((taken_r == 6'd0) ? ((addr & align_mask) == 16'd0)
                                        : (addr == base_r + {8'd0, taken_r, 2'd0}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_INIT;
      status_r    <= 32'h0000_0080;
      config_r    <= '0;
      control_r   <= '0;
      for (int i = 0; i < 8; i++) begin
        cmdw_r[i] <= '0;
      end
      base_r      <= '0;
      taken_r     <= '0;
      needed_r    <= '0;
      staged_r    <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      config_r    <= config_nxt;
      control_r   <= control_nxt;
      for (int i = 0; i < 8; i++) begin
        cmdw_r[i] <= cmdw_nxt[i];
      end
      base_r      <= base_nxt;
      taken_r     <= taken_nxt;
      needed_r    <= needed_nxt;
      staged_r    <= staged_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rd_r  <= out_rd_nxt;
    out_irq_r <= out_irq_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    config_nxt    = config_r;
    control_nxt   = control_r;
    cmdw_nxt      = cmdw_r;
    base_nxt      = base_r;
    taken_nxt     = taken_r;
    needed_nxt    = needed_r;
    staged_nxt    = staged_r;
    open_nxt      = open_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_rd_nxt    = out_rd_r;
    out_irq_nxt   = out_irq_r;
    produce       = 1'b0;
    blocked       = 1'b0;
    sw_start      = 1'b0;
    sw_cmd        = '0;
    case (state_r)
      T_INIT: begin
        if (sw_stat.done) begin
          state_nxt = T_IDLE;
        end
      end
      T_FREAD: begin
        produce    = 1'b1;
        out_rd_nxt = fl_rdata;
        state_nxt  = T_IDLE;
      end
      T_SWEEP: begin
        if (sw_stat.done) begin
          // The walk has ended: record any failure, close any window, give the result transfer and go back to idle.
          if (sw_stat.fail) begin
            status_nxt[fpec_pkg::ST_FAIL] = 1'b1;
          end
          status_nxt[fpec_pkg::ST_WIN_HI:fpec_pkg::ST_WIN_LO] = 2'd0;
          status_nxt[fpec_pkg::ST_READY] = 1'b0;
          status_nxt[fpec_pkg::ST_IDLE]  = 1'b1;
          open_nxt   = 1'b0;
          taken_nxt  = '0;
          produce    = 1'b1;
          out_rd_nxt = '0;
          state_nxt  = T_IDLE;
        end
      end
      T_IDLE: begin
        if (accept) begin
          produce    = 1'b1;
          out_rd_nxt = '0;
          case (op)
            fpec_pkg::OP_REG_RD: begin
              if (addr == fpec_pkg::REG_STATUS) begin
                out_rd_nxt = status_r;
              end else if (addr == fpec_pkg::REG_CONFIG) begin
                out_rd_nxt = config_r;
              end else if (addr == fpec_pkg::REG_CONTROL) begin
                out_rd_nxt = control_r;
              end else if (addr >= fpec_pkg::REG_CMD_LO && addr < fpec_pkg::REG_CMD_HI) begin
                out_rd_nxt = cmdw_r[cidx];
              end
            end
            fpec_pkg::OP_REG_WR: begin
              if (addr == fpec_pkg::REG_STATUS) begin
                // Launch is judged on the error bits held before this write.
                blocked    = (status_r & fpec_pkg::ST_ERRORS) != 32'd0;
                status_nxt = status_r & ~(wdata & fpec_pkg::ST_ERRORS);
                if (wdata[fpec_pkg::ST_READY] && status_r[fpec_pkg::ST_READY]) begin
                  // Commit of a filled window. The window base is aligned to
                  // its length, so the range never passes the end of flash.
                  status_nxt[fpec_pkg::ST_READY] = 1'b0;
                  if (staged_r == fpec_pkg::CMD_PRG_PAGE || staged_r == fpec_pkg::CMD_PRG_PHR) begin
                    sw_start     = 1'b1;
                    sw_cmd.mode  = fpec_pkg::MODE_PROG;
                    sw_cmd.first = base_r[fpec_pkg::FW_AW+1:2];
                    sw_cmd.last  = fpec_pkg::FW_AW'(needed_r - 6'd1);
                    produce      = 1'b0;
                    state_nxt    = T_SWEEP;
                  end else if (staged_r == fpec_pkg::CMD_ERS_SEC) begin
                    // A freshly erased sector always passes its read-ones check.
                    sw_start     = 1'b1;
                    sw_cmd.mode  = fpec_pkg::MODE_ERASE;
                    sw_cmd.first = fpec_pkg::FW_AW'(base_r[fpec_pkg::FW_AW+1:2] &
                                   ~fpec_pkg::FW_AW'(fpec_pkg::SECTOR_WORDS - 1));
                    sw_cmd.last  = fpec_pkg::FW_AW'(fpec_pkg::SECTOR_WORDS - 1);
                    produce      = 1'b0;
                    state_nxt    = T_SWEEP;
                  end else begin
                    status_nxt[fpec_pkg::ST_WIN_HI:fpec_pkg::ST_WIN_LO] = 2'd0;
                    status_nxt[fpec_pkg::ST_IDLE] = 1'b1;
                    open_nxt  = 1'b0;
                    taken_nxt = '0;
                  end
                end else if (wdata[fpec_pkg::ST_IDLE] && status_r[fpec_pkg::ST_IDLE] && !blocked) begin
                  status_nxt[fpec_pkg::ST_IDLE] = 1'b0;
                  sw_cmd.mode  = fpec_pkg::MODE_CHECK;
                  sw_cmd.first = caddr[fpec_pkg::FW_AW+1:2];
                  case (cmd)
                    fpec_pkg::CMD_ERS_ALL: begin
                      sw_start     = 1'b1;
                      sw_cmd.mode  = fpec_pkg::MODE_ERASE;
                      sw_cmd.first = '0;
                      sw_cmd.last  = fpec_pkg::FW_AW'(fpec_pkg::FLASH_WORDS - 1);
                    end
                    fpec_pkg::CMD_CHK_ALL: begin
                      sw_start     = 1'b1;
                      sw_cmd.first = '0;
                      sw_cmd.last  = fpec_pkg::FW_AW'(fpec_pkg::FLASH_WORDS - 1);
                    end
                    fpec_pkg::CMD_CHK_BLK: begin
                      sw_start     = 1'b1;
                      sw_cmd.first = caddr[fpec_pkg::FW_AW+1:2] &
                                     ~fpec_pkg::FW_AW'(fpec_pkg::HALF_WORDS - 1);
                      sw_cmd.last  = fpec_pkg::FW_AW'(fpec_pkg::HALF_WORDS - 1);
                    end
                    fpec_pkg::CMD_CHK_SEC: begin
                      sw_start    = (caddr & 16'(fpec_pkg::SECTOR_BYTES - 1)) == 16'd0;
                      sw_cmd.last = fpec_pkg::FW_AW'(fpec_pkg::SECTOR_WORDS - 1);
                    end
                    fpec_pkg::CMD_CHK_PAGE: begin
                      sw_start    = (caddr & 16'(fpec_pkg::PAGE_BYTES - 1)) == 16'd0;
                      sw_cmd.last = fpec_pkg::FW_AW'(fpec_pkg::PAGE_WORDS - 1);
                    end
                    fpec_pkg::CMD_CHK_PHR: begin
                      sw_start    = (caddr & 16'(fpec_pkg::PHRASE_BYTES - 1)) == 16'd0;
                      sw_cmd.last = fpec_pkg::FW_AW'(fpec_pkg::PHRASE_WORDS - 1);
                    end
                    fpec_pkg::CMD_PRG_PAGE: begin
                      staged_nxt = cmd;
                      needed_nxt = 6'(fpec_pkg::PAGE_WORDS);
                      taken_nxt  = '0;
                      base_nxt   = '0;
                      open_nxt   = 1'b1;
                      status_nxt[fpec_pkg::ST_READY] = 1'b0;
                      status_nxt[fpec_pkg::ST_WIN_HI:fpec_pkg::ST_WIN_LO] = fpec_pkg::WIN_PAGE;
                    end
                    fpec_pkg::CMD_PRG_PHR, fpec_pkg::CMD_ERS_SEC: begin
                      staged_nxt = cmd;
                      needed_nxt = 6'(fpec_pkg::PHRASE_WORDS);
                      taken_nxt  = '0;
                      base_nxt   = '0;
                      open_nxt   = 1'b1;
                      status_nxt[fpec_pkg::ST_READY] = 1'b0;
                      status_nxt[fpec_pkg::ST_WIN_HI:fpec_pkg::ST_WIN_LO] = fpec_pkg::WIN_PHRASE;
                    end
                    default: begin
                      // Unknown code; a check at a misaligned address is flagged below.
                      status_nxt[fpec_pkg::ST_ACCERR] = 1'b1;
                      status_nxt[fpec_pkg::ST_IDLE]   = 1'b1;
                    end
                  endcase
                  if (cmd >= fpec_pkg::CMD_CHK_SEC && cmd <= fpec_pkg::CMD_CHK_PHR && !sw_start) begin
                    status_nxt[fpec_pkg::ST_ACCERR] = 1'b1;
                    status_nxt[fpec_pkg::ST_IDLE]   = 1'b1;
                  end
                  if (sw_start) begin
                    produce   = 1'b0;
                    state_nxt = T_SWEEP;
                  end
                end
              end else if (addr == fpec_pkg::REG_CONFIG) begin
                config_nxt = wdata;
              end else if (addr == fpec_pkg::REG_CONTROL) begin
                control_nxt = wdata;
                control_nxt[fpec_pkg::CTL_ABORT] = 1'b0;
                if (wdata[fpec_pkg::CTL_ABORT] && open_r) begin
                  status_nxt[fpec_pkg::ST_ABT]   = 1'b1;
                  status_nxt[fpec_pkg::ST_WIN_HI:fpec_pkg::ST_WIN_LO] = 2'd0;
                  status_nxt[fpec_pkg::ST_READY] = 1'b0;
                  status_nxt[fpec_pkg::ST_IDLE]  = 1'b1;
                  open_nxt  = 1'b0;
                  taken_nxt = '0;
                end
              end else if (addr >= fpec_pkg::REG_CMD_LO && addr < fpec_pkg::REG_CMD_HI) begin
                if (status_r[fpec_pkg::ST_IDLE]) begin
                  cmdw_nxt[cidx] = wdata;
                end
              end
            end
            fpec_pkg::OP_FL_ST: begin
              if (sb_we) begin
                if (taken_r == 6'd0) begin
                  base_nxt = addr;
                end
                taken_nxt = taken_r + 6'd1;
                if (taken_r + 6'd1 == needed_r) begin
                  status_nxt[fpec_pkg::ST_WIN_HI:fpec_pkg::ST_WIN_LO] = 2'd0;
                  status_nxt[fpec_pkg::ST_READY] = 1'b1;
                end
              end else if (open_r &&
                           status_r[fpec_pkg::ST_WIN_HI:fpec_pkg::ST_WIN_LO] != 2'd0) begin
                // Wrong width, misaligned first word or a gap: abandon the window.
                status_nxt[fpec_pkg::ST_ACCERR] = 1'b1;
                status_nxt[fpec_pkg::ST_WIN_HI:fpec_pkg::ST_WIN_LO] = 2'd0;
                status_nxt[fpec_pkg::ST_READY] = 1'b0;
                status_nxt[fpec_pkg::ST_IDLE]  = 1'b1;
                open_nxt  = 1'b0;
                taken_nxt = '0;
              end
            end
            fpec_pkg::OP_FL_RD: begin
              produce   = 1'b0;
              state_nxt = T_FREAD;
            end
            default: begin
              produce = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
    if (produce) begin
      out_valid_nxt = 1'b1;
      out_irq_nxt   = status_nxt[fpec_pkg::ST_IDLE] && config_nxt[fpec_pkg::CFG_IE];
    end
  end

  fpec_sweep u_sweep (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (sw_start),
    .cmd_i      (sw_cmd),
    .fl_rdata_i (fl_rdata),
    .sb_rdata_i (sb_rdata),
    .req_o      (sw_req),
    .stat_o     (sw_stat)
  );

  // Flash array: the walk owns the port except for a bus read, which only
  // happens while no walk is running.
  fpec_ram #(
    .WIDTH (32),
    .DEPTH (fpec_pkg::FLASH_WORDS)
  ) u_flash (
    .clk   (clk),
    .we    (sw_req.fl_we),
    .waddr (sw_req.fl_waddr),
    .wdata (sw_req.fl_wdata),
    .re    (sw_req.fl_re || cpu_re),
    .raddr (cpu_re ? addr[fpec_pkg::FW_AW+1:2] : sw_req.fl_raddr),
    .rdata (fl_rdata)
  );

  // Staging buffer for the words of an open window.
  fpec_ram #(
    .WIDTH (32),
    .DEPTH (fpec_pkg::PAGE_WORDS)
  ) u_stage (
    .clk   (clk),
    .we    (sb_we),
    .waddr (taken_r[fpec_pkg::SB_AW-1:0]),
    .wdata (wdata),
    .re    (sw_req.fl_re),
    .raddr (sw_req.sb_raddr),
    .rdata (sb_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_irq_r, out_rd_r};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sw_stat.busy)
    else $error("input transfer offered while the array walk runs");
  a_window_closed: assert property (@(posedge clk) disable iff (!rst_n)
    !open_r |-> (status_r[fpec_pkg::ST_WIN_HI:fpec_pkg::ST_WIN_LO] == 2'd0 &&
                 !status_r[fpec_pkg::ST_READY]))
    else $error("window status set with no open window");
  a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r <= needed_r)
    else $error("more window words taken than needed");
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sw_stat.done |-> (state_r == T_SWEEP || state_r == T_INIT))
    else $error("array walk finished outside a walk state");

endmodule
